FILE: src/cumulative_histogram_engine_top_assert.svh
// Assertion macros used by the checker of the cumulative histogram engine.
`ifndef CUMULATIVE_HISTOGRAM_ENGINE_TOP_ASSERT_SVH
`define CUMULATIVE_HISTOGRAM_ENGINE_TOP_ASSERT_SVH

// Checked at every rising edge outside reset.
`define CHG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define CHG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/chg_pkg.sv
//------------------------------------------------------------------------------
// chg_pkg
// Shared types and constants of the cumulative histogram engine.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package chg_pkg;

  localparam int SUM_W    = 48;
  localparam int PROP_W   = 17;
  localparam int BIN_W    = 8;
  localparam int WEIGHT_W = 16;
  localparam int QDEPTH   = 4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_BUILT = 2'd1;
  localparam logic [1:0] ST_ZERO      = 2'd2;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_BUILD,
    OP_QUERY,
    OP_NOP
  } op_t;

  // Classified beat as handed from the front to the back.
  typedef struct packed {
    op_t                 op;
    logic [BIN_W-1:0]    idx;      // query index already clamped to the last bin
    logic                inrange;
    logic [WEIGHT_W-1:0] weight;
  } item_t;

endpackage

FILE: src/cumulative_histogram_engine_top.sv
//------------------------------------------------------------------------------
// cumulative_histogram_engine_top
// Histogram with saturating bins, a built cumulative table and share queries.
//------------------------------------------------------------------------------
// After reset the engine sweeps the bin memory to zero, one bin per cycle, and
// takes no beat before the sweep ends. Each beat carries a mode in tuser: add
// puts the weight into a bin (saturating at COUNT_WIDTH bits) and marks the
// cumulative table stale, build walks every bin to form running sums (each
// saturating at 48 bits) and the total, and query returns the cumulative count
// of a bin and floor(cumulative * 65536 / total) as unsigned Q1.16. Every beat
// returns exactly one result beat; add, build and the unused mode answer with
// zeros. A query before a build, or after an add, reports status 1 with zero
// data, and a zero total reports status 2.
// Beats land in a four-entry queue and are executed one at a time by the back
// end. An add reads the bin memory and then writes it back, a build reads and
// then accumulates each bin in turn, and a query reads the cumulative table and
// then runs the 17-step restoring divider. The result sits in an output
// register, so the queue keeps filling while a result waits to be taken.
`timescale 1ns / 1ps

module cumulative_histogram_engine_top
  import chg_pkg::*;
#(
  parameter int NUM_BINS    = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] bin, [23:8] weight
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [16:0] proportion, [64:17] cumulative, zero fill
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  logic              q_valid;
  item_t             q_item;
  logic              q_pop;
  logic              clearing;
  logic [PROP_W-1:0] out_prop;
  logic [SUM_W-1:0]  out_cum;

  chg_front #(
    .NUM_BINS (NUM_BINS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_mode   (s_axis_tuser),
    .in_bin    (s_axis_tdata[7:0]),
    .in_weight (s_axis_tdata[23:8]),
    .clearing  (clearing),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  chg_back #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_prop   (out_prop),
    .out_cum    (out_cum),
    .out_status (m_axis_tuser)
  );

  assign m_axis_tdata = {7'd0, out_cum, out_prop};

endmodule

FILE: src/chg_front.sv
//------------------------------------------------------------------------------
// chg_front
// Accepts input beats, classifies them and queues them for the back end.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module chg_front
  import chg_pkg::*;
#(
  parameter int NUM_BINS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_mode,
  input  logic [BIN_W-1:0]    in_bin,
  input  logic [WEIGHT_W-1:0] in_weight,
  input  logic                clearing,
  output logic                q_valid,
  output item_t               q_item,
  input  logic                q_pop
);

  localparam int PW = $clog2(QDEPTH);

  item_t         fifo [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  item_t         cls;
  logic          push;

  always_comb begin
    cls.inrange = (17'(in_bin) < 17'(NUM_BINS));
    cls.weight  = in_weight;
    // An out-of-range index only exists when the table is smaller than 256 bins.
    cls.idx     = cls.inrange ? in_bin : BIN_W'(NUM_BINS - 1);
    case (in_mode)
      MODE_ADD:   cls.op = OP_ADD;
      MODE_BUILD: cls.op = OP_BUILD;
      MODE_QUERY: cls.op = OP_QUERY;
      default:    cls.op = OP_NOP;
    endcase
  end

  assign in_ready = !clearing && (count != (PW+1)'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_item   = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/chg_div.sv
//------------------------------------------------------------------------------
// chg_div
// Restoring divider giving floor(num * 65536 / den) for num <= den.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module chg_div
  import chg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  num,
  input  logic [SUM_W-1:0]  den,
  output logic              done,
  output logic [PROP_W-1:0] quot
);

  localparam int CW = $clog2(PROP_W + 1);

  logic [SUM_W:0]   rem;
  logic [SUM_W-1:0] dsr;
  logic [CW-1:0]    cnt;
  logic             ge;
  logic [SUM_W:0]   diff;

  // One quotient bit per cycle; the first step has no shift.
  always_comb begin
    ge   = (rem >= {1'b0, dsr});
    diff = ge ? (rem - {1'b0, dsr}) : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= {1'b0, num};
        dsr <= den;
        cnt <= CW'(PROP_W);
      end else if (cnt != '0) begin
        rem  <= {diff[SUM_W-1:0], 1'b0};
        quot <= {quot[PROP_W-2:0], ge};
        cnt  <= cnt - 1'b1;
        done <= (cnt == CW'(1));
      end
    end
  end

endmodule

FILE: src/chg_back.sv
//------------------------------------------------------------------------------
// chg_back
// Executes queued beats against the bin and cumulative memories.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module chg_back
  import chg_pkg::*;
#(
  parameter int NUM_BINS    = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  output logic              clearing,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PROP_W-1:0] out_prop,
  output logic [SUM_W-1:0]  out_cum,
  output logic [1:0]        out_status
);

  localparam int IW = $clog2(NUM_BINS);
  localparam logic [IW-1:0]  Last   = IW'(NUM_BINS - 1);
  localparam logic [SUM_W:0] CntMax = ({{SUM_W{1'b0}}, 1'b1} << COUNT_WIDTH) - 1'b1;
  localparam logic [SUM_W:0] SumMax = {1'b0, {SUM_W{1'b1}}};

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ADD_RD, S_ADD_WR, S_BLD_RD, S_BLD_ACC,
    S_QRY_RD, S_QRY_CHK, S_QRY_DIV, S_EMIT
  } state_t;

  state_t                 state;
  item_t                  cur;
  logic [IW-1:0]          k;
  logic [SUM_W-1:0]       run;
  logic [SUM_W-1:0]       total;
  logic                   built;
  logic [PROP_W-1:0]      res_prop;
  logic [SUM_W-1:0]       res_cum;
  logic [1:0]             res_status;

  logic [COUNT_WIDTH-1:0] bin_mem [NUM_BINS];
  logic [SUM_W-1:0]       cum_mem [NUM_BINS];
  logic [COUNT_WIDTH-1:0] bin_rd;
  logic [SUM_W-1:0]       cum_rd;
  logic [IW-1:0]          cur_addr;
  logic [IW-1:0]          bin_raddr;
  logic                   bin_we;
  logic [IW-1:0]          bin_waddr;
  logic [COUNT_WIDTH-1:0] bin_wdata;
  logic                   cum_we;

  logic [SUM_W:0]         add_sum;
  logic [SUM_W:0]         run_sum;
  logic [SUM_W-1:0]       run_next;

  logic                   div_start;
  logic                   div_done;
  logic [PROP_W-1:0]      div_quot;

  assign cur_addr  = IW'(cur.idx);
  assign bin_raddr = (state == S_BLD_RD) ? k : cur_addr;
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign clearing  = (state == S_CLR);
  assign div_start = (state == S_QRY_CHK) && (total != '0);

  always_comb begin
    add_sum  = (SUM_W+1)'(bin_rd) + (SUM_W+1)'(cur.weight);
    run_sum  = {1'b0, run} + (SUM_W+1)'(bin_rd);
    run_next = (run_sum > SumMax) ? SumMax[SUM_W-1:0] : run_sum[SUM_W-1:0];
    bin_we   = 1'b0;
    bin_waddr = cur_addr;
    bin_wdata = (add_sum > CntMax) ? CntMax[COUNT_WIDTH-1:0] : add_sum[COUNT_WIDTH-1:0];
    if (state == S_CLR) begin
      bin_we    = 1'b1;
      bin_waddr = k;
      bin_wdata = '0;
    end else if (state == S_ADD_WR) begin
      bin_we    = cur.inrange;
    end
    cum_we = (state == S_BLD_ACC);
  end

  always_ff @(posedge clk) begin
    if (bin_we) begin
      bin_mem[bin_waddr] <= bin_wdata;
    end
    bin_rd <= bin_mem[bin_raddr];
  end

  always_ff @(posedge clk) begin
    if (cum_we) begin
      cum_mem[k] <= run_next;
    end
    cum_rd <= cum_mem[cur_addr];
  end

  chg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (cum_rd),
    .den   (total),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      k         <= '0;
      built     <= 1'b0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      // The emit state reloads the output register itself.
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          k <= k + 1'b1;
          if (k == Last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cur        <= q_item;
            res_prop   <= '0;
            res_cum    <= '0;
            res_status <= ST_OK;
            run        <= '0;
            k          <= '0;
            case (q_item.op)
              OP_ADD: begin
                built <= 1'b0;
                state <= S_ADD_RD;
              end
              OP_BUILD: state <= S_BLD_RD;
              OP_QUERY: begin
                if (built) begin
                  state <= S_QRY_RD;
                end else begin
                  res_status <= ST_NOT_BUILT;
                  state      <= S_EMIT;
                end
              end
              default: state <= S_EMIT;
            endcase
          end
        end
        S_ADD_RD:  state <= S_ADD_WR;
        S_ADD_WR:  state <= S_EMIT;
        S_BLD_RD:  state <= S_BLD_ACC;
        S_BLD_ACC: begin
          run <= run_next;
          if (k == Last) begin
            total <= run_next;
            built <= 1'b1;
            state <= S_EMIT;
          end else begin
            k     <= k + 1'b1;
            state <= S_BLD_RD;
          end
        end
        S_QRY_RD: state <= S_QRY_CHK;
        S_QRY_CHK: begin
          res_cum <= cum_rd;
          if (total == '0) begin
            res_status <= ST_ZERO;
            state      <= S_EMIT;
          end else begin
            state <= S_QRY_DIV;
          end
        end
        S_QRY_DIV: begin
          if (div_done) begin
            res_prop <= div_quot;
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            out_prop   <= res_prop;
            out_cum    <= res_cum;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/chg_checker.sv
//------------------------------------------------------------------------------
// chg_checker
// Port-level checks of the cumulative histogram engine.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cumulative_histogram_engine_top_assert.svh"

module chg_checker
  import chg_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  `CHG_ASSERT_ALWAYS(a_clear_after_reset, $past(rst) |-> !(s_axis_tvalid && s_axis_tready), "beat taken during clearing")
  `CHG_ASSERT(a_hold_result, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
  `CHG_ASSERT(a_not_built_zero, m_axis_tvalid && m_axis_tuser == ST_NOT_BUILT |-> m_axis_tdata == '0, "stale query returned data")
  `CHG_ASSERT(a_prop_range, m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tdata[15:0] == '0, "proportion above one")
  `CHG_ASSERT(a_status_code, m_axis_tvalid |-> m_axis_tuser <= ST_ZERO, "undefined status")

endmodule

bind cumulative_histogram_engine_top chg_checker u_chg_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: test/testbench.sv
//------------------------------------------------------------------------------
// testbench
// Self-checking bench for the cumulative histogram engine.
//------------------------------------------------------------------------------
// Beats are offered on the input stream from a table of directed rows, then
// from mostly well-formed add / build / query sequences. A behavioral copy of
// the histogram predicts every result beat. Expected beats are queued in order
// and each output beat is compared field by field with the oldest one. Both
// sides idle at random, in several phases.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import chg_pkg::*;

  localparam int NBINS    = 256;
  localparam int CNT_W    = 32;
  localparam int N_RANDOM = 1340;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [PROP_W-1:0] proportion;
    logic [SUM_W-1:0]  cumulative;
    logic [1:0]        status;
  } result_t;

  typedef struct {
    op_t         op;
    logic [7:0]  bin;
    logic [15:0] weight;
    bit          typed;      // when set, the result below is checked directly
    result_t     result;
  } row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // Predictor state: a private copy of the histogram and the built table.
  logic [CNT_W-1:0] hist_bins [NBINS];
  logic [SUM_W-1:0] hist_cum [NBINS];
  logic [SUM_W-1:0] hist_total;
  bit               hist_built;

  result_t pending_results[$];
  int      errors;
  int      stall_pct;
  int      idle_pct;
  int      idle_cycles;
  bit      hold_off;

  cumulative_histogram_engine_top #(.NUM_BINS(NBINS), .COUNT_WIDTH(CNT_W)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Apply one accepted beat to the private histogram and return its result.
  function automatic result_t histogram_step(op_t op, logic [7:0] bin, logic [15:0] weight);
    result_t    r;
    logic [SUM_W:0] run;
    logic [CNT_W:0] cnt;
    logic [SUM_W+16:0] scaled;
    r = '0;
    case (op)
      OP_ADD: begin
        hist_built = 1'b0;
        cnt = {1'b0, hist_bins[bin]} + weight;
        hist_bins[bin] = cnt[CNT_W] ? '1 : cnt[CNT_W-1:0];
      end
      OP_BUILD: begin
        run = '0;
        for (int k = 0; k < NBINS; k++) begin
          run = run + hist_bins[k];
          if (run[SUM_W]) run = {1'b0, {SUM_W{1'b1}}};
          hist_cum[k] = run[SUM_W-1:0];
        end
        hist_total = run[SUM_W-1:0];
        hist_built = 1'b1;
      end
      OP_QUERY: begin
        if (!hist_built) begin
          r.status = ST_NOT_BUILT;
        end else begin
          r.cumulative = hist_cum[bin];
          if (hist_total == 0) begin
            r.status = ST_ZERO;
          end else begin
            scaled = {hist_cum[bin], 16'd0};
            scaled = scaled / hist_total;
            r.proportion = scaled[PROP_W-1:0];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one beat and hold it until it is taken; the result is predicted then.
  // The valid line is left high; the next beat or the drain takes it down.
  task automatic send_beat(op_t op, logic [7:0] bin, logic [15:0] weight,
                           bit typed, result_t typed_result);
    result_t r;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {weight, bin};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    r = histogram_step(op, bin, weight);
    if (typed && r !== typed_result) begin
      $display("%0t: table row disagrees with predictor: row %h predictor %h",
               $time, typed_result, r);
      errors++;
    end
    pending_results.push_back(typed ? typed_result : r);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Well-formed burst: several adds, a build, then queries with random bins.
  task automatic send_sequence();
    int n_add;
    int n_query;
    logic [15:0] w;
    n_add   = $urandom_range(8, 1);
    n_query = $urandom_range(6, 1);
    for (int i = 0; i < n_add; i++) begin
      case ($urandom_range(3))
        0: w = 16'hFFFF;
        1: w = 16'd0;
        default: w = 16'($urandom);
      endcase
      send_beat(OP_ADD, 8'($urandom), w, 1'b0, '0);
    end
    send_beat(OP_BUILD, '0, 16'($urandom), 1'b0, '0);
    for (int i = 0; i < n_query; i++)
      send_beat(OP_QUERY, 8'($urandom), 16'($urandom), 1'b0, '0);
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each result beat with the oldest expected one.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.proportion = m_axis_tdata[16:0];
      got.cumulative = m_axis_tdata[64:17];
      got.status     = m_axis_tuser;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.proportion !== want.proportion) begin
          $display("%0t: proportion expected %h actual %h", $time, want.proportion,
                   got.proportion);
          errors++;
        end
        if (got.cumulative !== want.cumulative) begin
          $display("%0t: cumulative expected %h actual %h", $time, want.cumulative,
                   got.cumulative);
          errors++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %h actual %h", $time, want.status, got.status);
          errors++;
        end
      end
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  row_t rows[$];

  function automatic row_t mk(op_t op, logic [7:0] bin, logic [15:0] weight,
                              bit typed = 1'b0, logic [1:0] status = ST_OK);
    row_t r;
    r.op = op;
    r.bin = bin;
    r.weight = weight;
    r.typed = typed;
    r.result = '0;
    r.result.status = status;
    return r;
  endfunction

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    errors        = 0;
    stall_pct     = 0;
    idle_pct      = 0;
    idle_cycles   = 0;
    hold_off      = 1'b0;
    for (int k = 0; k < NBINS; k++) begin
      hist_bins[k] = '0;
      hist_cum[k]  = '0;
    end
    hist_total = '0;
    hist_built = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: reset state, zero total, extremes and no-op.
    rows.push_back(mk(OP_QUERY, 8'd0,   16'd0,    1'b1, ST_NOT_BUILT));
    rows.push_back(mk(OP_NOP,   8'hFF,  16'hFFFF, 1'b1, ST_OK));
    rows.push_back(mk(OP_BUILD, 8'd0,   16'd0,    1'b1, ST_OK));
    rows.push_back(mk(OP_QUERY, 8'hFF,  16'hFFFF, 1'b1, ST_ZERO));
    rows.push_back(mk(OP_ADD,   8'd0,   16'd0,    1'b1, ST_OK));
    rows.push_back(mk(OP_QUERY, 8'd0,   16'd0,    1'b1, ST_NOT_BUILT));
    rows.push_back(mk(OP_BUILD, 8'd0,   16'd0));
    rows.push_back(mk(OP_QUERY, 8'd0,   16'd0,    1'b1, ST_ZERO));
    rows.push_back(mk(OP_ADD,   8'd0,   16'hFFFF));
    rows.push_back(mk(OP_ADD,   8'hFF,  16'd1));
    rows.push_back(mk(OP_ADD,   8'h80,  16'hAAAA));
    rows.push_back(mk(OP_ADD,   8'h55,  16'h5555));
    rows.push_back(mk(OP_BUILD, 8'hFF,  16'hFFFF));
    rows.push_back(mk(OP_QUERY, 8'd0,   16'd0));
    rows.push_back(mk(OP_QUERY, 8'h55,  16'd0));
    rows.push_back(mk(OP_QUERY, 8'hAA,  16'd0));
    rows.push_back(mk(OP_QUERY, 8'hFF,  16'd0));
    rows.push_back(mk(OP_NOP,   8'd3,   16'd7,    1'b1, ST_OK));
    rows.push_back(mk(OP_QUERY, 8'hFE,  16'd0));
    foreach (rows[i])
      send_beat(rows[i].op, rows[i].bin, rows[i].weight, rows[i].typed, rows[i].result);
    drain_results();

    // Long receiver hold-off while the sender keeps offering beats.
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    for (int i = 0; i < 12; i++)
      send_beat(OP_ADD, 8'($urandom), 16'($urandom), 1'b0, '0);
    drain_results();

    // Pile full-weight adds onto one bin so that it dominates the total.
    for (int i = 0; i < 70; i++) send_beat(OP_ADD, 8'd7, 16'hFFFF, 1'b0, '0);
    send_beat(OP_BUILD, '0, '0, 1'b0, '0);
    send_beat(OP_QUERY, 8'd7, '0, 1'b0, '0);

    // Random phases with different idling on each side.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      for (int n = 0; n < N_RANDOM / 4; ) begin
        if ($urandom_range(9) < 8) begin
          send_sequence();
          n += 9;
        end else begin
          send_beat(op_t'($urandom_range(3)), 8'($urandom), 16'($urandom), 1'b0, '0);
          n++;
        end
      end
      // Sender pauses until every expected result has come.
      drain_results();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
